### rtl/ecpa_pkg.sv
// Shared types, constants and the microcode table of the projective point adder.
// No dependencies; every other file in rtl imports this package.
package ecpa_pkg;

   localparam int FIELD_BITS = 64;  // width of a field element, 8..64
   localparam int REG_BITS   = 64;  // width of register and port fields
   localparam int SLOT_BITS  = 5;
   localparam int PC_BITS    = 6;
   localparam int IMM_BITS   = 8;

   typedef logic [FIELD_BITS-1:0] felem_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [PC_BITS-1:0]    pc_type;

   typedef enum logic [3:0] {
      OP_RED,    // dst = input field (imm) mod p
      OP_REDA,   // dst = curve coefficient mod p
      OP_MUL,    // dst = srca * srcb mod p
      OP_MULK,   // dst = srca * imm mod p
      OP_ADD,    // dst = srca + srcb mod p
      OP_SUB,    // dst = srca - srcb mod p
      OP_BRINF,  // branch on either point being infinity
      OP_BEQ,    // branch to doubling when srca == srcb
      OP_END     // result complete, path code in imm
   } op_type;

   typedef struct packed {
      op_type                op;
      slot_type              dst;
      slot_type              srca;
      slot_type              srcb;
      logic [IMM_BITS-1:0]   imm;
   } uop_type;

   typedef struct packed {
      logic      rd_en;
      slot_type  rd_addr_a;
      slot_type  rd_addr_b;
      logic      wr_en;
      slot_type  wr_addr;
      felem_type wr_data;
   } rf_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_WAIT,
      ST_DONE
   } seq_state_type;

   // Register map index, taken from paddr[3].
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_COEFF   = 1'b1;

   localparam logic [1:0] PATH_P_INF  = 2'd0;
   localparam logic [1:0] PATH_Q_INF  = 2'd1;
   localparam logic [1:0] PATH_DOUBLE = 2'd2;
   localparam logic [1:0] PATH_ADD    = 2'd3;

   localparam pc_type PC_DOUBLE = 6'd33;
   localparam pc_type PC_P_INF  = 6'd56;
   localparam pc_type PC_Q_INF  = 6'd60;

   // Operand memory slots.
   localparam slot_type SL_PX = 5'd0,  SL_PY = 5'd1,  SL_PZ = 5'd2;
   localparam slot_type SL_QX = 5'd3,  SL_QY = 5'd4,  SL_QZ = 5'd5;
   localparam slot_type SL_CA = 5'd6,  SL_T0 = 5'd7,  SL_T1 = 5'd8;
   localparam slot_type SL_T2 = 5'd9,  SL_T3 = 5'd10, SL_U  = 5'd11;
   localparam slot_type SL_T4 = 5'd12, SL_T5 = 5'd13, SL_V  = 5'd14;
   localparam slot_type SL_V2 = 5'd15, SL_V3 = 5'd16, SL_ZZ = 5'd17;
   localparam slot_type SL_T  = 5'd18, SL_UU = 5'd19, SL_W1 = 5'd20;
   localparam slot_type SL_W2 = 5'd21, SL_W  = 5'd22, SL_TW = 5'd23;
   localparam slot_type SL_Y1 = 5'd24, SL_Y2 = 5'd25, SL_S  = 5'd26;
   localparam slot_type SL_XS = 5'd27, SL_A1 = 5'd28, SL_RX = 5'd29;
   localparam slot_type SL_RY = 5'd30, SL_RZ = 5'd31;

   function automatic uop_type mk(op_type op, slot_type dst, slot_type a, slot_type b,
                                  logic [IMM_BITS-1:0] imm);
      uop_type u;
      u.op   = op;
      u.dst  = dst;
      u.srca = a;
      u.srcb = b;
      u.imm  = imm;
      return u;
   endfunction

   function automatic uop_type ucode(pc_type pc);
      uop_type u;
      unique case (pc)
         // Reduce all inputs and the coefficient.
         6'd0:  u = mk(OP_RED,   SL_PX, SL_PX, SL_PX, 8'd0);
         6'd1:  u = mk(OP_RED,   SL_PY, SL_PX, SL_PX, 8'd1);
         6'd2:  u = mk(OP_RED,   SL_PZ, SL_PX, SL_PX, 8'd2);
         6'd3:  u = mk(OP_RED,   SL_QX, SL_PX, SL_PX, 8'd3);
         6'd4:  u = mk(OP_RED,   SL_QY, SL_PX, SL_PX, 8'd4);
         6'd5:  u = mk(OP_RED,   SL_QZ, SL_PX, SL_PX, 8'd5);
         6'd6:  u = mk(OP_REDA,  SL_CA, SL_PX, SL_PX, 8'd0);
         6'd7:  u = mk(OP_BRINF, SL_PX, SL_PX, SL_PX, 8'd0);
         6'd8:  u = mk(OP_MUL,   SL_T0, SL_PX, SL_QY, 8'd0);
         6'd9:  u = mk(OP_MUL,   SL_T1, SL_QX, SL_PY, 8'd0);
         6'd10: u = mk(OP_BEQ,   SL_PX, SL_T0, SL_T1, 8'd0);
         // General addition.
         6'd11: u = mk(OP_MUL,   SL_T2, SL_QY, SL_PZ, 8'd0);
         6'd12: u = mk(OP_MUL,   SL_T3, SL_PY, SL_QZ, 8'd0);
         6'd13: u = mk(OP_SUB,   SL_U,  SL_T2, SL_T3, 8'd0);
         6'd14: u = mk(OP_MUL,   SL_T4, SL_QX, SL_PZ, 8'd0);
         6'd15: u = mk(OP_MUL,   SL_T5, SL_PX, SL_QZ, 8'd0);
         6'd16: u = mk(OP_SUB,   SL_V,  SL_T4, SL_T5, 8'd0);
         6'd17: u = mk(OP_MUL,   SL_V2, SL_V,  SL_V,  8'd0);
         6'd18: u = mk(OP_MUL,   SL_V3, SL_V2, SL_V,  8'd0);
         6'd19: u = mk(OP_MUL,   SL_ZZ, SL_PZ, SL_QZ, 8'd0);
         6'd20: u = mk(OP_MUL,   SL_T,  SL_V2, SL_T5, 8'd0);
         6'd21: u = mk(OP_MUL,   SL_UU, SL_U,  SL_U,  8'd0);
         6'd22: u = mk(OP_MUL,   SL_W1, SL_UU, SL_ZZ, 8'd0);
         6'd23: u = mk(OP_SUB,   SL_W1, SL_W1, SL_V3, 8'd0);
         6'd24: u = mk(OP_MULK,  SL_W2, SL_T,  SL_T,  8'd2);
         6'd25: u = mk(OP_SUB,   SL_W,  SL_W1, SL_W2, 8'd0);
         6'd26: u = mk(OP_MUL,   SL_RX, SL_V,  SL_W,  8'd0);
         6'd27: u = mk(OP_SUB,   SL_TW, SL_T,  SL_W,  8'd0);
         6'd28: u = mk(OP_MUL,   SL_Y1, SL_U,  SL_TW, 8'd0);
         6'd29: u = mk(OP_MUL,   SL_Y2, SL_V3, SL_T3, 8'd0);
         6'd30: u = mk(OP_SUB,   SL_RY, SL_Y1, SL_Y2, 8'd0);
         6'd31: u = mk(OP_MUL,   SL_RZ, SL_V3, SL_ZZ, 8'd0);
         6'd32: u = mk(OP_END,   SL_PX, SL_PX, SL_PX, 8'(PATH_ADD));
         // Doubling.
         6'd33: u = mk(OP_MUL,   SL_A1, SL_PX, SL_PX, 8'd0);
         6'd34: u = mk(OP_MULK,  SL_A1, SL_A1, SL_A1, 8'd3);
         6'd35: u = mk(OP_MUL,   SL_T2, SL_PZ, SL_PZ, 8'd0);
         6'd36: u = mk(OP_MUL,   SL_T2, SL_CA, SL_T2, 8'd0);
         6'd37: u = mk(OP_ADD,   SL_U,  SL_A1, SL_T2, 8'd0);
         6'd38: u = mk(OP_MUL,   SL_V,  SL_PY, SL_PZ, 8'd0);
         6'd39: u = mk(OP_MUL,   SL_S,  SL_PY, SL_V,  8'd0);
         6'd40: u = mk(OP_MUL,   SL_XS, SL_PX, SL_S,  8'd0);
         6'd41: u = mk(OP_MUL,   SL_UU, SL_U,  SL_U,  8'd0);
         6'd42: u = mk(OP_MULK,  SL_T4, SL_XS, SL_XS, 8'd8);
         6'd43: u = mk(OP_SUB,   SL_W,  SL_UU, SL_T4, 8'd0);
         6'd44: u = mk(OP_MUL,   SL_T,  SL_V,  SL_W,  8'd0);
         6'd45: u = mk(OP_MULK,  SL_RX, SL_T,  SL_T,  8'd2);
         6'd46: u = mk(OP_MULK,  SL_T5, SL_XS, SL_XS, 8'd4);
         6'd47: u = mk(OP_SUB,   SL_TW, SL_T5, SL_W,  8'd0);
         6'd48: u = mk(OP_MUL,   SL_Y1, SL_U,  SL_TW, 8'd0);
         6'd49: u = mk(OP_MUL,   SL_T0, SL_S,  SL_S,  8'd0);
         6'd50: u = mk(OP_MULK,  SL_T1, SL_T0, SL_T0, 8'd8);
         6'd51: u = mk(OP_SUB,   SL_RY, SL_Y1, SL_T1, 8'd0);
         6'd52: u = mk(OP_MUL,   SL_V2, SL_V,  SL_V,  8'd0);
         6'd53: u = mk(OP_MUL,   SL_V3, SL_V,  SL_V2, 8'd0);
         6'd54: u = mk(OP_MULK,  SL_RZ, SL_V3, SL_V3, 8'd8);
         6'd55: u = mk(OP_END,   SL_PX, SL_PX, SL_PX, 8'(PATH_DOUBLE));
         // First point is infinity: copy the second.
         6'd56: u = mk(OP_MULK,  SL_RX, SL_QX, SL_QX, 8'd1);
         6'd57: u = mk(OP_MULK,  SL_RY, SL_QY, SL_QY, 8'd1);
         6'd58: u = mk(OP_MULK,  SL_RZ, SL_QZ, SL_QZ, 8'd1);
         6'd59: u = mk(OP_END,   SL_PX, SL_PX, SL_PX, 8'(PATH_P_INF));
         // Second point is infinity: copy the first.
         6'd60: u = mk(OP_MULK,  SL_RX, SL_PX, SL_PX, 8'd1);
         6'd61: u = mk(OP_MULK,  SL_RY, SL_PY, SL_PY, 8'd1);
         6'd62: u = mk(OP_MULK,  SL_RZ, SL_PZ, SL_PZ, 8'd1);
         6'd63: u = mk(OP_END,   SL_PX, SL_PX, SL_PX, 8'(PATH_Q_INF));
         default: u = mk(OP_END, SL_PX, SL_PX, SL_PX, 8'(PATH_ADD));
      endcase
      return u;
   endfunction

endpackage

### rtl/ecpa_regfile.sv
// Operand memory of the point adder: 32 field elements, two read ports, one write port.
// Depends on ecpa_pkg.
module ecpa_regfile (
   input  logic                    clock,
   input  ecpa_pkg::rf_req_type    req,
   output ecpa_pkg::felem_type     rd_data_a,
   output ecpa_pkg::felem_type     rd_data_b
);
   import ecpa_pkg::*;

   felem_type mem [2**SLOT_BITS];
   felem_type rd_a_ff;
   felem_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_a_ff <= mem[req.rd_addr_a];
         rd_b_ff <= mem[req.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/ecpa_modmul.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle, most significant first.
// Depends on ecpa_pkg.
module ecpa_modmul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  ecpa_pkg::felem_type               mcand,
   input  logic [ecpa_pkg::REG_BITS-1:0]     mplier,
   input  ecpa_pkg::felem_type               modulus,
   output logic                              done,
   output ecpa_pkg::felem_type               product
);
   import ecpa_pkg::*;

   localparam int CNT_BITS = $clog2(REG_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   felem_type           a_ff, a_in;
   logic [REG_BITS-1:0] b_ff, b_in;
   felem_type           r_ff, r_in;

   logic [FIELD_BITS:0] dbl;
   felem_type           dbl_red;
   logic [FIELD_BITS:0] acc;
   felem_type           acc_red;

   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? FIELD_BITS'(dbl - {1'b0, modulus})
                                         : FIELD_BITS'(dbl);
      acc     = {1'b0, dbl_red} + {1'b0, a_ff};
      acc_red = (acc >= {1'b0, modulus}) ? FIELD_BITS'(acc - {1'b0, modulus})
                                         : FIELD_BITS'(acc);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(REG_BITS - 1);
         a_in    = mcand;
         b_in    = mplier;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = b_ff[REG_BITS-1] ? acc_red : dbl_red;
         b_in   = {b_ff[REG_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

### rtl/ecpa_csr.sv
// Configuration registers of the point adder behind a simple bus port.
// Depends on ecpa_pkg.
module ecpa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [3:0]                     csr_paddr,
   input  logic [ecpa_pkg::REG_BITS-1:0]  csr_pwdata,
   output logic [ecpa_pkg::REG_BITS-1:0]  csr_prdata,
   output logic                           csr_pready,
   output ecpa_pkg::felem_type            modulus,
   output logic [ecpa_pkg::REG_BITS-1:0]  coeff
);
   import ecpa_pkg::*;

   logic [REG_BITS-1:0] modulus_ff;
   logic [REG_BITS-1:0] coeff_ff;
   felem_type           mod_masked;
   logic                wr_strobe;

   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= REG_BITS'(3);
         coeff_ff   <= '0;
      end else if (wr_strobe) begin
         unique case (csr_paddr[3])
            CSR_MODULUS: modulus_ff <= csr_pwdata;
            CSR_COEFF:   coeff_ff   <= csr_pwdata;
            default:     modulus_ff <= modulus_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         CSR_MODULUS: csr_prdata = modulus_ff;
         CSR_COEFF:   csr_prdata = coeff_ff;
         default:     csr_prdata = '0;
      endcase
   end

   // Moduli below three act as three.
   assign mod_masked = modulus_ff[FIELD_BITS-1:0];
   assign modulus    = (mod_masked < FIELD_BITS'(3)) ? FIELD_BITS'(3) : mod_masked;
   assign coeff      = coeff_ff;
   assign csr_pready = 1'b1;

endmodule

### rtl/ec_point_add_prime_field.sv
// Projective point adder over GF(p): a microcoded sequencer around one operand memory
// and one bit-serial modular multiplier that runs one bit per cycle. Items are processed
// one at a time; a new item does not start until the last result has been handed over.
// One item waits in the input buffer and one result in the output register meanwhile.
// Synchronous active-high reset clears control state and sets the modulus to 3.
module ec_point_add_prime_field (
   input  logic          clock,
   input  logic          reset,
   // Input items: first_x, first_y, first_z, second_x, second_y, second_z (lowest first).
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [383:0]  req_tdata,
   // Results: sum_x, sum_y, sum_z (lowest first).
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [191:0]  rsp_tdata,
   // Result kind: path_taken.
   output logic [1:0]    rsp_tuser,
   // Configuration port.
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import ecpa_pkg::*;

   // Input buffer. It is released as soon as all six coordinates have been reduced
   // into the operand memory, so the next transfer can land while this item runs.
   logic                in_valid_ff, in_valid_in;
   logic [383:0]        in_data_ff;

   // Sequencer.
   seq_state_type       state_ff, state_in;
   pc_type              pc_ff, pc_in;
   uop_type             uop;

   // Infinity flags of the six reduced coordinates, captured as they are written.
   logic [5:0]          zero_ff, zero_in;
   logic [5:0]          one_ff, one_in;
   logic                p_inf, q_inf;

   // Result staging and output register.
   felem_type           res_x_ff, res_x_in;
   felem_type           res_y_ff, res_y_in;
   felem_type           res_z_ff, res_z_in;
   logic                out_valid_ff, out_valid_in;
   logic [191:0]        out_data_ff, out_data_in;
   logic [1:0]          out_path_ff, out_path_in;

   rf_req_type          rf_req;
   felem_type           rd_a, rd_b;

   logic                mm_start, mm_done;
   felem_type           mm_a, mm_p;
   logic [REG_BITS-1:0] mm_b;
   felem_type           mm_product;
   logic [REG_BITS-1:0] coeff;
   logic [REG_BITS-1:0] field_raw;

   logic [FIELD_BITS:0] add_sum;
   felem_type           add_res, sub_res;
   felem_type           wr_value;

   ecpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .modulus     (mm_p),
      .coeff       (coeff)
   );

   ecpa_regfile u_regfile (
      .clock     (clock),
      .req       (rf_req),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   ecpa_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .mcand   (mm_a),
      .mplier  (mm_b),
      .modulus (mm_p),
      .done    (mm_done),
      .product (mm_product)
   );

   assign uop   = ucode(pc_ff);
   assign p_inf = zero_ff[0] && one_ff[1] && zero_ff[2];
   assign q_inf = zero_ff[3] && one_ff[4] && zero_ff[5];

   // Input coordinate for a reduction step, cut to the field width.
   always_comb begin
      unique case (uop.imm[2:0])
         3'd0:    field_raw = in_data_ff[63:0];
         3'd1:    field_raw = in_data_ff[127:64];
         3'd2:    field_raw = in_data_ff[191:128];
         3'd3:    field_raw = in_data_ff[255:192];
         3'd4:    field_raw = in_data_ff[319:256];
         3'd5:    field_raw = in_data_ff[383:320];
         default: field_raw = '0;
      endcase
   end

   // Combinational modular add and subtract on operands already below p.
   always_comb begin
      add_sum = {1'b0, rd_a} + {1'b0, rd_b};
      add_res = (add_sum >= {1'b0, mm_p}) ? FIELD_BITS'(add_sum - {1'b0, mm_p})
                                          : FIELD_BITS'(add_sum);
      sub_res = (rd_a >= rd_b) ? (rd_a - rd_b) : (rd_a + (mm_p - rd_b));
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      in_valid_in  = in_valid_ff;
      zero_in      = zero_ff;
      one_in       = one_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_path_in  = out_path_ff;
      mm_start     = 1'b0;
      mm_a         = rd_a;
      mm_b         = REG_BITS'(rd_b);
      wr_value     = mm_product;

      rf_req.rd_en     = 1'b0;
      rf_req.rd_addr_a = uop.srca;
      rf_req.rd_addr_b = uop.srcb;
      rf_req.wr_en     = 1'b0;
      rf_req.wr_addr   = uop.dst;
      rf_req.wr_data   = mm_product;

      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid_ff) begin
               pc_in    = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rf_req.rd_en = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FETCH;
            unique case (uop.op)
               OP_RED: begin
                  mm_start = 1'b1;
                  mm_a     = FIELD_BITS'(1);
                  mm_b     = REG_BITS'(field_raw[FIELD_BITS-1:0]);
                  state_in = ST_WAIT;
               end
               OP_REDA: begin
                  mm_start = 1'b1;
                  mm_a     = FIELD_BITS'(1);
                  mm_b     = coeff;
                  state_in = ST_WAIT;
               end
               OP_MUL: begin
                  mm_start = 1'b1;
                  state_in = ST_WAIT;
               end
               OP_MULK: begin
                  mm_start = 1'b1;
                  mm_b     = REG_BITS'(uop.imm);
                  state_in = ST_WAIT;
               end
               OP_ADD, OP_SUB: begin
                  wr_value       = (uop.op == OP_ADD) ? add_res : sub_res;
                  rf_req.wr_en   = 1'b1;
                  rf_req.wr_data = wr_value;
                  pc_in          = pc_ff + 1'b1;
               end
               OP_BRINF: begin
                  // The coordinates now live in the operand memory.
                  in_valid_in = 1'b0;
                  if (p_inf) begin
                     pc_in = PC_P_INF;
                  end else if (q_inf) begin
                     pc_in = PC_Q_INF;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
               OP_BEQ: begin
                  pc_in = (rd_a == rd_b) ? PC_DOUBLE : pc_ff + 1'b1;
               end
               OP_END: begin
                  state_in = ST_DONE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WAIT: begin
            if (mm_done) begin
               rf_req.wr_en = 1'b1;
               pc_in        = pc_ff + 1'b1;
               state_in     = ST_FETCH;
               if (uop.op == OP_RED) begin
                  zero_in[uop.dst[2:0]] = (mm_product == '0);
                  one_in[uop.dst[2:0]]  = (mm_product == FIELD_BITS'(1));
               end
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free or being drained.
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {REG_BITS'(res_z_ff), REG_BITS'(res_y_ff), REG_BITS'(res_x_ff)};
               out_path_in  = uop.imm[1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // The result coordinates are caught on their way into the operand memory.
      if (rf_req.wr_en) begin
         if (rf_req.wr_addr == SL_RX) res_x_in = rf_req.wr_data;
         if (rf_req.wr_addr == SL_RY) res_y_in = rf_req.wr_data;
         if (rf_req.wr_addr == SL_RZ) res_z_in = rf_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         zero_ff      <= '0;
         one_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         zero_ff      <= zero_in;
         one_ff       <= one_in;
      end
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      out_data_ff <= out_data_in;
      out_path_ff <= out_path_in;
   end

   assign req_tready = !in_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_path_ff;

endmodule
